[hw/rtl/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg: shared constants for the file signature classifier
// Signature table, result codes and small table lookup helpers.
// ----------------------------------------------------------------------------
package fsc_pkg;

	localparam int HEADER_BYTES = 128;
	localparam int POS_W        = $clog2(HEADER_BYTES + 1);
	localparam int NUM_SIGS     = 38;
	localparam int PAT_BYTES    = 20;
	localparam int PAT_W        = 8 * PAT_BYTES;
	localparam int KIND_W       = 6;
	localparam int MIME_W       = 7;

	localparam int SIG_PNG = 3;

	localparam logic [KIND_W-1:0] KIND_APNG       = 6'd37;
	localparam logic [KIND_W-1:0] KIND_NONE       = 6'd38;
	localparam logic [KIND_W-1:0] KIND_LAST_ENTRY = 6'd39;
	localparam logic [MIME_W-1:0] MIME_APNG       = 7'd23;
	localparam logic [MIME_W-1:0] MIME_UNKNOWN    = 7'd101;

	// PNG chunk fields
	localparam int LEN_POS   = 8;   // big-endian IHDR length, bytes 8..11
	localparam int IHDR_POS  = 12;  // IHDR tag, bytes 12..15
	localparam int ACTL_BASE = 24;  // acTL tag at 24 + length
	localparam logic [31:0] TAG_IHDR = "IHDR";
	localparam logic [31:0] TAG_ACTL = "acTL";
	localparam logic [31:0] MAX_CHUNK = 32'(HEADER_BYTES - ACTL_BASE - 4);

	// signature table: offset, length, mime code, pattern left aligned
	localparam logic [7:0] SIG_OFF [NUM_SIGS] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
		8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd8, 8'd8, 8'd0
	};

	localparam logic [4:0] SIG_LEN [NUM_SIGS] = '{
		5'd2, 5'd7, 5'd6, 5'd4, 5'd4, 5'd4, 5'd4, 5'd2, 5'd4, 5'd4,
		5'd3, 5'd3, 5'd3, 5'd3, 5'd4, 5'd6, 5'd6, 5'd8, 5'd4, 5'd4,
		5'd4, 5'd6, 5'd7, 5'd8, 5'd20, 5'd7, 5'd8, 5'd7, 5'd8, 5'd8,
		5'd8, 5'd8, 5'd6, 5'd4, 5'd4, 5'd4, 5'd3, 5'd16
	};

	localparam logic [MIME_W-1:0] SIG_MIME [NUM_SIGS] = '{
		7'd1, 7'd3, 7'd3, 7'd2, 7'd33, 7'd34, 7'd34, 7'd4, 7'd7, 7'd7,
		7'd5, 7'd5, 7'd5, 7'd9, 7'd10, 7'd10, 7'd10, 7'd45, 7'd11, 7'd11,
		7'd11, 7'd32, 7'd31, 7'd31, 7'd12, 7'd14, 7'd14, 7'd14, 7'd14, 7'd14,
		7'd14, 7'd14, 7'd26, 7'd16, 7'd46, 7'd46, 7'd27, 7'd19
	};

	localparam logic [PAT_W-1:0] SIG_PAT [NUM_SIGS] = '{
		{8'hFF, 8'hD8, 144'h0},
		{"GIF87a", 8'h00, 104'h0},
		{"GIF89a", 112'h0},
		{8'h89, "PNG", 128'h0},
		{"WEBP", 128'h0},
		{"II*", 8'h00, 128'h0},
		{"MM", 8'h00, "*", 128'h0},
		{"BM", 144'h0},
		{32'h00000100, 128'h0},
		{32'h00000200, 128'h0},
		{"CWS", 136'h0},
		{"FWS", 136'h0},
		{"ZWS", 136'h0},
		{"FLV", 136'h0},
		{"%PDF", 128'h0},
		{"8BPS", 16'h0001, 112'h0},
		{"8BPS", 16'h0002, 112'h0},
		{"CSFCHUNK", 96'h0},
		{"PK", 16'h0304, 128'h0},
		{"PK", 16'h0506, 128'h0},
		{"PK", 16'h0708, 128'h0},
		{"7z", 32'hBCAF271C, 112'h0},
		{56'h526172211A0700, 104'h0},
		{64'h526172211A070100, 96'h0},
		{64'h6879647275732065, 64'h6E63727970746564, 32'h207A6970},
		{"ftypmp4", 104'h0},
		{"ftypisom", 96'h0},
		{"ftypM4V", 104'h0},
		{"ftypMSNV", 96'h0},
		{"ftypavc1", 96'h0},
		{"ftypFACE", 96'h0},
		{"ftypdash", 96'h0},
		{"ftypqt", 112'h0},
		{"fLaC", 128'h0},
		{"RIFF", 128'h0},
		{"WAVE", 128'h0},
		{"AVI", 136'h0},
		{64'h3026B2758E66CF11, 64'hA6D900AA0062CE6C, 32'h0}
	};

	// final flags handed from the tracker to the result stage
	typedef struct packed {
		logic [NUM_SIGS-1:0] alive;
		logic                apng_ok;
	} fsc_final_t;

	// byte k of signature i
	function automatic logic [7:0] sig_byte(input int i, input logic [4:0] k);
		logic [PAT_W-1:0] sh;
		sh = SIG_PAT[i] << {k, 3'b000};
		return sh[PAT_W-1 -: 8];
	endfunction

	// byte j of a four-byte tag
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] j);
		logic [31:0] sh;
		sh = tag << {j, 3'b000};
		return sh[31:24];
	endfunction

	// zero padding from position q onward clears signature i
	function automatic logic pad_kills(input int i, input logic [POS_W-1:0] q);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < PAT_BYTES; k++) begin
			if (k < int'(SIG_LEN[i]) && sig_byte(i, 5'(k)) != 8'h00 &&
					(int'(SIG_OFF[i]) + k) >= int'(q))
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

[hw/rtl/file_signature_classifier.sv]
// ----------------------------------------------------------------------------
// file_signature_classifier: file type detection from header bytes
// Streams a file header one byte per item and reports the file type.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one header byte per item in
//    data_byte, position counted from zero; last marks the final byte.
//    Up to 128 bytes are examined; later bytes are taken and ignored, and a
//    short header is judged as if padded with zero bytes.
//  - Output channel (out_valid/out_ready): one result item per header,
//    kind (table entry, animated PNG or no match) and mime_code.
//  - Throughput: one byte per cycle, sustained while no last byte waits
//    for the result slot, set by the single input register feeding all
//    signature compares in parallel.
//  - Result path: the last byte passes the input register, then the result
//    register, before its result is offered on out_valid.
//  - Stall: while a result waits, bytes without last keep flowing; a last
//    byte waits in the input register until the result slot frees, and
//    in_ready stays low meanwhile.
//  - Reset: arst_n clears all tracking state; the first byte after reset
//    is position zero of a new header.
// ----------------------------------------------------------------------------
module file_signature_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fsc_pkg::KIND_W-1:0]  kind,
	output logic [fsc_pkg::MIME_W-1:0]  mime_code
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic                 res_free;  // result slot can take a new result
	logic                 advance;   // stage 1 item moves on this cycle
	fsc_pkg::fsc_final_t  fin;

	// a byte without last never needs the result slot
	assign advance  = valid_s1 && (!last_s1 || res_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	fsc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.fin       (fin)
	);

	fsc_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && last_s1),
		.fin       (fin),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (res_free),
		.kind      (kind),
		.mime_code (mime_code)
	);

	// a last byte must hold while the result slot is blocked
	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("last byte left stage 1 while result was blocked");

	// a new result only follows a last byte
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last byte");

	// special kinds carry their fixed mime codes
	a_code_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fsc_pkg::KIND_APNG || kind == fsc_pkg::KIND_NONE) |->
			(kind == fsc_pkg::KIND_APNG && mime_code == fsc_pkg::MIME_APNG) ||
			(kind == fsc_pkg::KIND_NONE && mime_code == fsc_pkg::MIME_UNKNOWN))
		else $error("kind and mime code disagree");

endmodule

[hw/rtl/fsc_track.sv]
// ----------------------------------------------------------------------------
// fsc_track: per-header match tracking
// Running match flags, PNG chunk length and tag checks, plus the
// zero-padding closeout for the final byte.
// ----------------------------------------------------------------------------
module fsc_track (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,      // byte in stage 1 moves on
	input  logic [7:0]             data_byte,
	input  logic                   last,
	output fsc_pkg::fsc_final_t    fin
);

	logic [fsc_pkg::POS_W-1:0]    pos_q, pos_nx;
	logic [fsc_pkg::NUM_SIGS-1:0] alive_q, alive_nx, pad;
	logic [31:0]                  chunk_q, chunk_nx;
	logic                         ihdr_q, ihdr_nx;
	logic                         actl_q, actl_nx;
	logic                         take;
	logic [fsc_pkg::POS_W:0]      t_live, t_fin;
	logic                         win_live, win_fin;

	always_comb begin
		take     = pos_q < fsc_pkg::POS_W'(fsc_pkg::HEADER_BYTES);
		alive_nx = alive_q;
		chunk_nx = chunk_q;
		ihdr_nx  = ihdr_q;
		actl_nx  = actl_q;
		pos_nx   = pos_q;

		win_live = chunk_q <= fsc_pkg::MAX_CHUNK;
		t_live   = {1'b0, chunk_q[fsc_pkg::POS_W-1:0]} +
			(fsc_pkg::POS_W+1)'(fsc_pkg::ACTL_BASE);

		if (take) begin
			for (int i = 0; i < fsc_pkg::NUM_SIGS; i++) begin
				if (pos_q >= fsc_pkg::SIG_OFF[i] &&
						{1'b0, pos_q} < ({1'b0, fsc_pkg::SIG_OFF[i]} +
							9'(fsc_pkg::SIG_LEN[i])) &&
						data_byte != fsc_pkg::sig_byte(i, 5'(pos_q - fsc_pkg::SIG_OFF[i])))
					alive_nx[i] = 1'b0;
			end
			// length bytes go straight into their big-endian slot
			if (pos_q >= fsc_pkg::POS_W'(fsc_pkg::LEN_POS) &&
					pos_q < fsc_pkg::POS_W'(fsc_pkg::LEN_POS + 4)) begin
				case (2'(pos_q - fsc_pkg::POS_W'(fsc_pkg::LEN_POS)))
					2'd0:    chunk_nx[31:24] = data_byte;
					2'd1:    chunk_nx[23:16] = data_byte;
					2'd2:    chunk_nx[15:8]  = data_byte;
					default: chunk_nx[7:0]   = data_byte;
				endcase
			end
			if (pos_q >= fsc_pkg::POS_W'(fsc_pkg::IHDR_POS) &&
					pos_q < fsc_pkg::POS_W'(fsc_pkg::IHDR_POS + 4) &&
					data_byte != fsc_pkg::tag_byte(fsc_pkg::TAG_IHDR,
						2'(pos_q - fsc_pkg::POS_W'(fsc_pkg::IHDR_POS))))
				ihdr_nx = 1'b0;
			if (pos_q >= fsc_pkg::POS_W'(fsc_pkg::IHDR_POS) && win_live &&
					{1'b0, pos_q} >= t_live &&
					{1'b0, pos_q} < t_live + (fsc_pkg::POS_W+1)'(4) &&
					data_byte != fsc_pkg::tag_byte(fsc_pkg::TAG_ACTL,
						2'({1'b0, pos_q} - t_live)))
				actl_nx = 1'b0;
			pos_nx = pos_q + 1'b1;
		end

		// closeout: untaken positions read as zero
		for (int i = 0; i < fsc_pkg::NUM_SIGS; i++)
			pad[i] = fsc_pkg::pad_kills(i, pos_nx);
		win_fin = chunk_nx <= fsc_pkg::MAX_CHUNK;
		t_fin   = {1'b0, chunk_nx[fsc_pkg::POS_W-1:0]} +
			(fsc_pkg::POS_W+1)'(fsc_pkg::ACTL_BASE);

		fin.alive   = alive_nx & ~pad;
		fin.apng_ok = ihdr_nx && pos_nx >= fsc_pkg::POS_W'(fsc_pkg::IHDR_POS + 4) &&
			win_fin && actl_nx && {1'b0, pos_nx} >= t_fin + (fsc_pkg::POS_W+1)'(4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= '1;
			chunk_q <= '0;
			ihdr_q  <= 1'b1;
			actl_q  <= 1'b1;
		end else if (fire) begin
			if (last) begin
				pos_q   <= '0;
				alive_q <= '1;
				chunk_q <= '0;
				ihdr_q  <= 1'b1;
				actl_q  <= 1'b1;
			end else begin
				pos_q   <= pos_nx;
				alive_q <= alive_nx;
				chunk_q <= chunk_nx;
				ihdr_q  <= ihdr_nx;
				actl_q  <= actl_nx;
			end
		end
	end

endmodule

[hw/rtl/fsc_result.sv]
// ----------------------------------------------------------------------------
// fsc_result: result encoding and output register
// Picks the first live table entry, maps it to kind and mime code and
// holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module fsc_result (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  fsc_pkg::fsc_final_t         fin,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        free,
	output logic [fsc_pkg::KIND_W-1:0]  kind,
	output logic [fsc_pkg::MIME_W-1:0]  mime_code
);

	logic [fsc_pkg::KIND_W-1:0] kind_nx, kind_q;
	logic [fsc_pkg::MIME_W-1:0] mime_nx, mime_q;
	logic                       valid_q;
	logic                       found;
	logic [fsc_pkg::KIND_W-1:0] first;

	always_comb begin
		found = 1'b0;
		first = '0;
		for (int i = fsc_pkg::NUM_SIGS - 1; i >= 0; i--) begin
			if (fin.alive[i]) begin
				found = 1'b1;
				first = fsc_pkg::KIND_W'(i);
			end
		end

		if (!found) begin
			kind_nx = fsc_pkg::KIND_NONE;
			mime_nx = fsc_pkg::MIME_UNKNOWN;
		end else if (first == fsc_pkg::KIND_W'(fsc_pkg::SIG_PNG) && fin.apng_ok) begin
			kind_nx = fsc_pkg::KIND_APNG;
			mime_nx = fsc_pkg::MIME_APNG;
		end else begin
			// the final entry's own index collides with the APNG code
			kind_nx = (first == fsc_pkg::KIND_W'(fsc_pkg::NUM_SIGS - 1)) ?
				fsc_pkg::KIND_LAST_ENTRY : first;
			mime_nx = fsc_pkg::SIG_MIME[first];
		end
	end

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			kind_q <= kind_nx;
			mime_q <= mime_nx;
		end
	end

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign mime_code = mime_q;

endmodule

[tb/file_signature_classifier_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_signature_classifier_test: self-checking bench for the classifier
// Streams directed and random file headers one byte per item, predicts the
// type reported for each header, and checks every result item in order.
// ----------------------------------------------------------------------------
module file_signature_classifier_test;

	localparam int CLK_PERIOD     = 10;
	localparam int WINDOW         = fsc_pkg::HEADER_BYTES;
	localparam int ENTRIES        = fsc_pkg::NUM_SIGS;
	localparam int PNG_ENTRY      = fsc_pkg::SIG_PNG;
	localparam int RIFF_ENTRY     = 34;
	localparam int WAVE_ENTRY     = 35;
	localparam int AVI_ENTRY      = 36;
	localparam int LEN_AT         = 8;   // big-endian chunk length
	localparam int IHDR_AT        = 12;
	localparam int ACTL_AT        = 24;  // acTL expected at this + length
	localparam int MAX_CHUNK_LEN  = WINDOW - ACTL_AT - 4;
	localparam logic [31:0] IHDR_TAG = "IHDR";
	localparam logic [31:0] ACTL_TAG = "acTL";
	localparam int STALL_LIMIT    = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_BYTES   = 100;
	localparam int RANDOM_HEADERS = 4;

	// one signature: offset, length, mime code, pattern right aligned
	typedef struct packed {
		logic [7:0]                 off;
		logic [7:0]                 len;
		logic [fsc_pkg::MIME_W-1:0] mime;
		logic [159:0]               pat;
	} signature_t;

	typedef struct packed {
		logic [fsc_pkg::KIND_W-1:0] kind;
		logic [fsc_pkg::MIME_W-1:0] mime;
	} file_type_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	logic [7:0]                  data_byte = 8'h00;
	logic                        last      = 1'b0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [fsc_pkg::KIND_W-1:0]  kind;
	logic [fsc_pkg::MIME_W-1:0]  mime_code;

	file_signature_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.mime_code (mime_code)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Signature list, kept in priority order: the lowest index that still
	// matches after the window wins.
	// ------------------------------------------------------------------
	function automatic signature_t entry(input int o, input int n, input int m,
			input logic [159:0] p);
		signature_t s;
		s.off  = 8'(o);
		s.len  = 8'(n);
		s.mime = m[fsc_pkg::MIME_W-1:0];
		s.pat  = p;
		return s;
	endfunction

	function automatic signature_t sig_desc(input int i);
		case (i)
			0:  return entry(0, 2, 1, 16'hFFD8);                 // JPEG
			1:  return entry(0, 7, 3, {"GIF87a", 8'h00});
			2:  return entry(0, 6, 3, "GIF89a");
			3:  return entry(0, 4, 2, {8'h89, "PNG"});
			4:  return entry(8, 4, 33, "WEBP");
			5:  return entry(0, 4, 34, {"II*", 8'h00});           // TIFF, little endian
			6:  return entry(0, 4, 34, {"MM", 8'h00, "*"});       // TIFF, big endian
			7:  return entry(0, 2, 4, "BM");
			8:  return entry(0, 4, 7, 32'h00000100);              // ICO
			9:  return entry(0, 4, 7, 32'h00000200);              // CUR
			10: return entry(0, 3, 5, "CWS");
			11: return entry(0, 3, 5, "FWS");
			12: return entry(0, 3, 5, "ZWS");
			13: return entry(0, 3, 9, "FLV");
			14: return entry(0, 4, 10, "%PDF");
			15: return entry(0, 6, 10, {"8BPS", 16'h0001});
			16: return entry(0, 6, 10, {"8BPS", 16'h0002});
			17: return entry(0, 8, 45, "CSFCHUNK");
			18: return entry(0, 4, 11, {"PK", 16'h0304});
			19: return entry(0, 4, 11, {"PK", 16'h0506});
			20: return entry(0, 4, 11, {"PK", 16'h0708});
			21: return entry(0, 6, 32, {"7z", 32'hBCAF271C});
			22: return entry(0, 7, 31, 56'h526172211A0700);       // RAR 1.5
			23: return entry(0, 8, 31, 64'h526172211A070100);     // RAR 5
			// encrypted archive wrapper, 20 bytes
			24: return entry(0, 20, 12, 160'h68796472757320656E63727970746564207A6970);
			25: return entry(4, 7, 14, "ftypmp4");
			26: return entry(4, 8, 14, "ftypisom");
			27: return entry(4, 7, 14, "ftypM4V");
			28: return entry(4, 8, 14, "ftypMSNV");
			29: return entry(4, 8, 14, "ftypavc1");
			30: return entry(4, 8, 14, "ftypFACE");
			31: return entry(4, 8, 14, "ftypdash");
			32: return entry(4, 6, 26, "ftypqt");
			33: return entry(0, 4, 16, "fLaC");
			34: return entry(0, 4, 46, "RIFF");
			35: return entry(8, 4, 46, "WAVE");
			36: return entry(8, 3, 27, "AVI");
			// ASF / WMV header object GUID, the final entry
			default: return entry(0, 16, 19, 128'h3026B2758E66CF11A6D900AA0062CE6C);
		endcase
	endfunction

	function automatic logic [7:0] pattern_byte(input signature_t s, input int k);
		return s.pat[8 * (int'(s.len) - 1 - k) +: 8];
	endfunction

	function automatic logic [7:0] tag_at(input logic [31:0] tag, input int j);
		return tag[31 - 8 * j -: 8];
	endfunction

	// ------------------------------------------------------------------
	// Header tracker: per-header state mirrored from accepted bytes.
	// ------------------------------------------------------------------
	int unsigned          trk_pos;
	logic [ENTRIES-1:0]   trk_alive;
	logic [31:0]          trk_len;
	logic                 trk_ihdr;
	logic                 trk_actl;
	file_type_t           pending_types[$];

	// stats for the summary
	int unsigned          headers_sent;
	int unsigned          bytes_sent;
	int unsigned          results_checked;
	int unsigned          apng_count;
	int unsigned          unmatched_count;
	logic [ENTRIES-1:0]   entries_seen = '0;
	int unsigned          mismatches;

	function automatic void clear_tracker();
		trk_pos   = 0;
		trk_alive = '1;
		trk_len   = '0;
		trk_ihdr  = 1'b1;
		trk_actl  = 1'b1;
	endfunction

	// chunk length is usable only if the acTL tag would fit in the window
	function automatic bit chunk_fits();
		return !trk_len[31] && (trk_len + 32'd28 <= WINDOW);
	endfunction

	function automatic void track_byte(input logic [7:0] b);
		signature_t  s;
		int unsigned p;
		int unsigned o;
		int unsigned n;
		int unsigned t;
		if (trk_pos >= WINDOW)
			return;  // past the window: taken, ignored
		p = trk_pos;
		for (int i = 0; i < ENTRIES; i++) begin
			s = sig_desc(i);
			o = s.off;
			n = s.len;
			if (p >= o && p < o + n && b != pattern_byte(s, p - o))
				trk_alive[i] = 1'b0;
		end
		if (p >= LEN_AT && p < LEN_AT + 4)
			trk_len = {trk_len[23:0], b};
		if (p >= IHDR_AT && p < IHDR_AT + 4 && b != tag_at(IHDR_TAG, p - IHDR_AT))
			trk_ihdr = 1'b0;
		if (p >= IHDR_AT && chunk_fits()) begin
			t = ACTL_AT + trk_len;
			if (p >= t && p < t + 4 && b != tag_at(ACTL_TAG, p - t))
				trk_actl = 1'b0;
		end
		trk_pos = p + 1;
	endfunction

	// last byte seen: pad the window with zeros, pick the winner, queue it
	function automatic void close_header();
		file_type_t want;
		signature_t s;
		int         first;
		while (trk_pos < WINDOW)
			track_byte(8'h00);
		first = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (trk_alive[i] && first < 0)
				first = i;
		if (first < 0) begin
			want.kind = fsc_pkg::KIND_NONE;
			want.mime = fsc_pkg::MIME_UNKNOWN;
			unmatched_count++;
		end else if (first == PNG_ENTRY && trk_ihdr && chunk_fits() && trk_actl) begin
			want.kind = fsc_pkg::KIND_APNG;
			want.mime = fsc_pkg::MIME_APNG;
			apng_count++;
		end else begin
			s = sig_desc(first);
			// kinds 37 and 38 are taken, so the final entry reports as its own code
			want.kind = (first == ENTRIES - 1) ? fsc_pkg::KIND_LAST_ENTRY
				: first[fsc_pkg::KIND_W-1:0];
			want.mime = s.mime;
			entries_seen[first] = 1'b1;
		end
		pending_types.push_back(want);
		clear_tracker();
	endfunction

	// input monitor: every accepted byte feeds the tracker
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			track_byte(data_byte);
			if (last)
				close_header();
		end
	end

	// result checker: compare against the oldest pending type
	always @(posedge clk) begin : check_results
		file_type_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_types.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind %0d mime %0d",
					$time, kind, mime_code);
				mismatches++;
			end else begin
				want = pending_types.pop_front();
				results_checked++;
				if (kind !== want.kind) begin
					$display("%0t: kind mismatch: expected %0d, actual %0d",
						$time, want.kind, kind);
					mismatches++;
				end
				if (mime_code !== want.mime) begin
					$display("%0t: mime_code mismatch: expected %0d, actual %0d",
						$time, want.mime, mime_code);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Flow control. calm forces zero waits so that back-to-back stretches
	// appear between the randomly stalled ones.
	// ------------------------------------------------------------------
	bit calm = 1'b0;

	function automatic int unsigned draw_wait();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// result side: after each result, drop ready for a drawn number of cycles
	int unsigned sink_hold;
	int unsigned sink_draw;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_hold <= 0;
		end else if (out_ready) begin
			if (out_valid) begin
				sink_draw = draw_wait();
				if (sink_draw != 0) begin
					out_ready <= 1'b0;
					sink_hold <= sink_draw;
				end
			end
		end else if (sink_hold <= 1) begin
			out_ready <= 1'b1;
		end else begin
			sink_hold <= sink_hold - 1;
		end
	end

	// watchdog: give up when no item moves on either side for too long
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT - 1) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Header building and sending
	// ------------------------------------------------------------------
	logic [7:0] hdr[$];
	bit         fill_random = 1'b0;

	task automatic grow_to(input int unsigned n);
		while (hdr.size() < n)
			hdr.push_back(fill_random ? 8'($urandom) : 8'h00);
	endtask

	task automatic put_byte(input int unsigned pos, input logic [7:0] b);
		grow_to(pos + 1);
		hdr[pos] = b;
	endtask

	task automatic put_sig(input int i);
		signature_t s;
		s = sig_desc(i);
		for (int k = 0; k < s.len; k++)
			put_byte(s.off + k, pattern_byte(s, k));
	endtask

	task automatic cut_to(input int unsigned n);
		while (hdr.size() > n)
			void'(hdr.pop_back());
	endtask

	// PNG with a given IHDR length; acTL bytes that fall inside the window
	// are placed at 24 + length
	task automatic build_png(input logic [31:0] clen, input bit ihdr_ok,
			input bit actl_ok, input int unsigned total);
		int unsigned t;
		hdr.delete();
		put_sig(PNG_ENTRY);
		for (int j = 0; j < 4; j++) begin
			put_byte(LEN_AT + j, clen[31 - 8 * j -: 8]);
			put_byte(IHDR_AT + j, tag_at(IHDR_TAG, j));
		end
		if (!ihdr_ok)
			hdr[IHDR_AT + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
		if (clen < WINDOW - ACTL_AT) begin
			t = ACTL_AT + clen;
			for (int j = 0; j < 4; j++)
				if (t + j < WINDOW)
					put_byte(t + j, tag_at(ACTL_TAG, j));
			if (!actl_ok && t + 3 < WINDOW)
				hdr[t + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
		end
		grow_to(total);
		cut_to(total);
	endtask

	// one byte per handshake; valid stays up once raised
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last      <= is_last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_header();
		grow_to(1);
		for (int k = 0; k < hdr.size(); k++)
			send_byte(hdr[k], k == hdr.size() - 1);
		headers_sent++;
		hdr.delete();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// every entry on its own, exact length, zero fill around it
	task automatic test_each_signature();
		fill_random = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			hdr.delete();
			put_sig(i);
			send_header();
		end
	endtask

	// RIFF sits ahead of WAVE and AVI and hides them
	task automatic test_container_shadowing();
		fill_random = 1'b1;
		hdr.delete();
		put_sig(RIFF_ENTRY);
		put_sig(WAVE_ENTRY);
		grow_to(20);
		send_header();
		hdr.delete();
		put_sig(RIFF_ENTRY);
		put_sig(AVI_ENTRY);
		send_header();
	endtask

	task automatic test_png_animation();
		fill_random = 1'b1;
		build_png(0, 1, 1, ACTL_AT + 4);                // acTL right after IHDR
		send_header();
		build_png(MAX_CHUNK_LEN, 1, 1, WINDOW + 4);     // acTL in the last four bytes,
		send_header();                                  // then bytes past the window
		build_png(MAX_CHUNK_LEN + 1, 1, 1, ACTL_AT + 4); // tag would cross the window
		send_header();
		build_png(32'h8000_0000, 1, 1, IHDR_AT + 4);    // negative length
		send_header();
		build_png(32'hFFFF_FFFF, 1, 1, IHDR_AT + 4);
		send_header();
		build_png(13, 0, 1, ACTL_AT + 13 + 4);          // no IHDR: plain PNG
		send_header();
		build_png(13, 1, 0, ACTL_AT + 13 + 4);          // broken acTL
		send_header();
		build_png(13, 1, 1, ACTL_AT + 13 + 2);          // ends inside acTL, zeros follow
		send_header();
	endtask

	task automatic test_header_lengths();
		fill_random = 1'b0;
		hdr.push_back(8'hFF);                       // single byte header
		send_header();
		hdr.push_back(8'h00);
		send_header();
		put_sig(1);                                 // GIF87a, trailing zero from padding
		cut_to(6);
		send_header();
	endtask

	task automatic random_signature_header();
		signature_t  s;
		int          i;
		int unsigned span;
		int unsigned total;
		i = $urandom_range(0, ENTRIES - 1);
		s = sig_desc(i);
		hdr.delete();
		put_sig(i);
		if (i == RIFF_ENTRY && $urandom_range(0, 1) == 1)
			put_sig($urandom_range(0, 1) ? WAVE_ENTRY : AVI_ENTRY);
		span = hdr.size();
		if ($urandom_range(0, 3) == 0)
			hdr[s.off + $urandom_range(0, s.len - 1)] ^= 8'($urandom_range(1, 255));
		case ($urandom_range(0, 15))
			0:       total = $urandom_range(1, span);                 // cut short
			1:       total = $urandom_range(WINDOW - 8, WINDOW + 72); // long header
			default: total = span + $urandom_range(0, 20);
		endcase
		grow_to(total);
		cut_to(total);
	endtask

	task automatic random_png_header();
		logic [31:0] clen;
		int unsigned total;
		case ($urandom_range(0, 7))
			0:       clen = $urandom();
			1:       clen = $urandom_range(MAX_CHUNK_LEN - 3, WINDOW);
			default: clen = $urandom_range(0, MAX_CHUNK_LEN);
		endcase
		total = (clen <= MAX_CHUNK_LEN) ? ACTL_AT + 4 + clen : IHDR_AT + 4;
		total += $urandom_range(0, 16);
		if ($urandom_range(0, 7) == 0)
			total = $urandom_range(1, total);
		build_png(clen, $urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0, total);
	endtask

	task automatic random_noise_header();
		hdr.delete();
		grow_to(($urandom_range(0, 7) == 0) ? $urandom_range(1, WINDOW + 12)
			: $urandom_range(1, 40));
	endtask

	// mostly well-formed headers with random content, the rest noise
	task automatic test_random_headers();
		int unsigned start_bytes;
		int unsigned start_headers;
		start_bytes   = bytes_sent;
		start_headers = headers_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES ||
				headers_sent - start_headers < RANDOM_HEADERS) begin
			if ($urandom_range(0, 7) == 0)
				calm = !calm;
			fill_random = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: random_signature_header();
				5, 6, 7:       random_png_header();
				default:       random_noise_header();
			endcase
			send_header();
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clear_tracker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_each_signature();
		test_container_shadowing();
		test_png_animation();
		test_header_lengths();
		test_random_headers();

		in_valid <= 1'b0;
		last     <= 1'b0;
		while (results_checked < headers_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Classified %0d headers from %0d bytes, %0d results compared.",
			headers_sent, bytes_sent, results_checked);
		$display("Animated PNG %0d, unmatched %0d, table entries reported %0d of %0d.",
			apng_count, unmatched_count, $countones(entries_seen), ENTRIES);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_track.sv
hw/rtl/fsc_result.sv
hw/rtl/file_signature_classifier.sv
tb/file_signature_classifier_test.sv
